// ===== rtl/core/crot_pkg.sv =====
// shared types, constants and lookup functions for the wireframe cube rotator
// no dependencies; imported by every module of the block
package crot_pkg;

    localparam int VERTEX_COUNT     = 8;
    localparam int EDGE_COUNT       = 12;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int VTX_W    = $clog2(VERTEX_COUNT);
    localparam int EDGE_W   = $clog2(EDGE_COUNT);
    localparam int COORD_W  = 10;
    localparam int VERT_W   = 26;
    localparam int FRAC_W   = 14;
    localparam int TIME_W   = 24;
    localparam int SPEED_W  = 24;
    localparam int COLOUR_W = 8;
    localparam int HALF_W   = 9;
    localparam int SINE_W   = 16;
    localparam int PHASE_W  = 16;
    localparam int DIFF_W   = VERT_W + 1;
    localparam int MULB_W   = SPEED_W + 1;
    localparam int MUL_W    = DIFF_W + MULB_W;
    localparam int ACC_W    = 43;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [2:0] PHASE_LAST = 3'd3;
    localparam logic [2:0] TRIG_LAST  = 3'd6;
    localparam logic [2:0] ROT_LAST   = 3'd5;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;

    localparam real PI_VAL = 3.14159265358979323846;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTRE_X     = 8'd0,
        CFG_CENTRE_Y     = 8'd1,
        CFG_HALF_SIZE    = 8'd2,
        CFG_SPEED_X      = 8'd3,
        CFG_SPEED_Y      = 8'd4,
        CFG_SPEED_Z      = 8'd5,
        CFG_COLOUR_CYCLE = 8'd6,
        CFG_START_COLOUR = 8'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_PHASE,
        ST_TRIG,
        ST_READ,
        ST_LOAD,
        ST_ROT,
        ST_WRITE,
        ST_EDGE_RD,
        ST_EDGE_OUT
    } crot_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]  centre_x;
        logic [COORD_W-1:0]  centre_y;
        logic [HALF_W-1:0]   half_size;
        logic [SPEED_W-1:0]  speed_x_axis;
        logic [SPEED_W-1:0]  speed_y_axis;
        logic [SPEED_W-1:0]  speed_z_axis;
        logic                colour_cycle;
        logic [COLOUR_W-1:0] start_colour;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        centre_x:     10'd128,
        centre_y:     10'd96,
        half_size:    9'd48,
        speed_x_axis: 24'd214748,
        speed_y_axis: 24'd644245,
        speed_z_axis: 24'd429497,
        colour_cycle: 1'b1,
        start_colour: 8'd1
    };

    typedef struct packed {
        logic              restart;
        logic [TIME_W-1:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x_start;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_end;
        logic [COLOUR_W-1:0] line_colour;
        logic                last_edge;
    } out_item_t;

    typedef struct packed {
        logic signed [VERT_W-1:0] x;
        logic signed [VERT_W-1:0] y;
        logic signed [VERT_W-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic              wr_en;
        logic [VTX_W-1:0]  wr_addr;
        vertex_t           wr_data;
        logic              rd_en;
        logic [VTX_W-1:0]  rd_addr_a;
        logic [VTX_W-1:0]  rd_addr_b;
    } mem_req_t;

    typedef struct packed {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
    } edge_pair_t;

    // corner i: x positive on 1,2 (mod 4), y positive on 2,3, z positive on upper four
    function automatic vertex_t cube_corner(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                            logic [HALF_W-1:0] h, logic [VTX_W-1:0] idx);
        vertex_t v;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic signed [11:0] sz;
        sx = (idx[0] ^ idx[1]) ? 12'({2'b0, cx} + {3'b0, h}) : 12'({2'b0, cx} - {3'b0, h});
        sy = idx[1] ? 12'({2'b0, cy} + {3'b0, h}) : 12'({2'b0, cy} - {3'b0, h});
        sz = idx[2] ? 12'({3'b0, h}) : 12'(12'd0 - {3'b0, h});
        v.x = {sx, {FRAC_W{1'b0}}};
        v.y = {sy, {FRAC_W{1'b0}}};
        v.z = {sz, {FRAC_W{1'b0}}};
        return v;
    endfunction

    function automatic edge_pair_t edge_ends(logic [EDGE_W-1:0] e);
        edge_pair_t p;
        unique case (e)
            4'd0:    p = '{a: 3'd0, b: 3'd1};
            4'd1:    p = '{a: 3'd1, b: 3'd2};
            4'd2:    p = '{a: 3'd2, b: 3'd3};
            4'd3:    p = '{a: 3'd3, b: 3'd0};
            4'd4:    p = '{a: 3'd4, b: 3'd5};
            4'd5:    p = '{a: 3'd5, b: 3'd6};
            4'd6:    p = '{a: 3'd6, b: 3'd7};
            4'd7:    p = '{a: 3'd7, b: 3'd4};
            4'd8:    p = '{a: 3'd0, b: 3'd4};
            4'd9:    p = '{a: 3'd1, b: 3'd5};
            4'd10:   p = '{a: 3'd2, b: 3'd6};
            4'd11:   p = '{a: 3'd3, b: 3'd7};
            default: p = '{a: 3'd0, b: 3'd0};
        endcase
        return p;
    endfunction

    // integer part (floor), clamped to the screen range
    function automatic logic [COORD_W-1:0] screen_coord(logic signed [VERT_W-1:0] v);
        logic signed [VERT_W-FRAC_W-1:0] p;
        p = v[VERT_W-1:FRAC_W];
        if (p < 0)
            return '0;
        if (p > 12'sd1023)
            return '1;
        return p[COORD_W-1:0];
    endfunction

    // round(16384*sin(2*pi*i/2^idx_w)), built from the first quadrant
    function automatic int sine_entry(int i, int idx_w);
        int  n;
        int  q;
        int  rem;
        int  r;
        real ang;
        n   = 1 << idx_w;
        q   = 0;
        rem = 4 * i;
        for (int k = 0; k < 3; k++) begin
            if (rem >= n) begin
                rem = rem - n;
                q   = q + 1;
            end
        end
        if (q % 2 == 1)
            rem = n - rem;
        ang = (PI_VAL / 2.0) * $itor(rem) * (2.0 ** (-idx_w));
        r   = $rtoi(16384.0 * $sin(ang) + 0.5);
        if (r > 16384)
            r = 16384;
        return (q >= 2) ? -r : r;
    endfunction

endpackage

// ===== rtl/core/crot_vertex_mem.sv =====
// vertex store: eight corners, one write port and two registered read ports
// depends on crot_pkg; entries never written since reset read as the reset cube
module crot_vertex_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  crot_pkg::mem_req_t req,
    output crot_pkg::vertex_t  rd_data_a,
    output crot_pkg::vertex_t  rd_data_b
);
    import crot_pkg::*;

    vertex_t                   mem [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0]   valid_reg;
    vertex_t                   rd_a_reg;
    vertex_t                   rd_b_reg;
    logic                      rd_a_valid_reg;
    logic                      rd_b_valid_reg;
    logic [VTX_W-1:0]          rd_a_addr_reg;
    logic [VTX_W-1:0]          rd_b_addr_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en) begin
            rd_a_reg      <= mem[req.rd_addr_a];
            rd_b_reg      <= mem[req.rd_addr_b];
            rd_a_addr_reg <= req.rd_addr_a;
            rd_b_addr_reg <= req.rd_addr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en) begin
                rd_a_valid_reg <= valid_reg[req.rd_addr_a];
                rd_b_valid_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    assign rd_data_a = rd_a_valid_reg ? rd_a_reg
        : cube_corner(CFG_RESET.centre_x, CFG_RESET.centre_y, CFG_RESET.half_size,
                      rd_a_addr_reg);
    assign rd_data_b = rd_b_valid_reg ? rd_b_reg
        : cube_corner(CFG_RESET.centre_x, CFG_RESET.centre_y, CFG_RESET.half_size,
                      rd_b_addr_reg);

endmodule

// ===== rtl/core/crot_sine_rom.sv =====
// sine table rom, entries round(16384*sin), one registered read a cycle
// depends on crot_pkg for the entry function
module crot_sine_rom #(
    parameter int SINE_ENTRIES = crot_pkg::SINE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(SINE_ENTRIES)-1:0]   rd_index,
    output logic signed [crot_pkg::SINE_W-1:0] rd_data
);
    import crot_pkg::*;

    localparam int IDX_W = $clog2(SINE_ENTRIES);

    typedef logic [SINE_ENTRIES*SINE_W-1:0] rom_bits_t;

    function automatic rom_bits_t build_rom();
        rom_bits_t bits;
        int        v;
        bits = '0;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            v = sine_entry(i, IDX_W);
            bits[i*SINE_W +: SINE_W] = SINE_W'(v);
        end
        return bits;
    endfunction

    localparam rom_bits_t ROM_BITS = build_rom();

    always_ff @(posedge clk) begin
        if (rd_en)
            rd_data <= $signed(ROM_BITS[rd_index*SINE_W +: SINE_W]);
    end

endmodule

// ===== rtl/core/crot_engine.sv =====
// frame sequencer and shared-multiplier datapath of the cube rotator
// depends on crot_pkg; drives the vertex store and the sine rom
module crot_engine #(
    parameter int SINE_ENTRIES = crot_pkg::SINE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  crot_pkg::cfg_t                     cfg,
    input  logic                               start,
    input  crot_pkg::in_item_t                 item,
    output logic                               busy,
    output logic                               emit_valid,
    input  logic                               emit_ready,
    output crot_pkg::out_item_t                emit_item,
    output crot_pkg::mem_req_t                 mem_req,
    input  crot_pkg::vertex_t                  rd_data_a,
    input  crot_pkg::vertex_t                  rd_data_b,
    output logic                               rom_rd_en,
    output logic [$clog2(SINE_ENTRIES)-1:0]    rom_index,
    input  logic signed [crot_pkg::SINE_W-1:0] rom_data
);
    import crot_pkg::*;

    localparam int IDX_W = $clog2(SINE_ENTRIES);

    crot_state_t state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [VTX_W-1:0]       vtx_reg, vtx_next;
    logic [1:0]             axis_reg, axis_next;
    logic [EDGE_W-1:0]      edge_reg, edge_next;
    logic [TIME_W-1:0]      time_last_reg, time_last_next;
    logic [COLOUR_W-1:0]    colour_reg, colour_next;
    logic [TIME_W-1:0]      delta_reg, delta_next;
    logic [2:0][PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0][SINE_W-1:0]  sin_reg, sin_next;
    logic [2:0][SINE_W-1:0]  cos_reg, cos_next;
    logic signed [MUL_W-1:0] mul_reg, mul_next;
    logic signed [ACC_W-1:0] acc_a_reg, acc_a_next;
    logic signed [ACC_W-1:0] acc_b_reg, acc_b_next;
    vertex_t                 work_reg, work_next;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [MUL_W-1:0]  mul_prod;

    logic signed [VERT_W-1:0] op_a, op_b;
    logic signed [DIFF_W-1:0] ctr_a, ctr_b;
    logic signed [DIFF_W-1:0] diff_a, diff_b;
    logic signed [SINE_W-1:0] sin_sel, cos_sel;
    logic signed [ACC_W-1:0]  sum_a, sum_b;
    logic signed [VERT_W-1:0] new_a, new_b;
    logic [DIFF_W-1:0]        cx_fix, cy_fix;
    logic [1:0]               ph_slot;
    logic [2:0]               trig_slot;
    logic [PHASE_W-1:0]       trig_phase, cos_phase;
    logic [SPEED_W-1:0]       speed_sel;
    edge_pair_t               pair;

    assign mul_prod = mul_a * mul_b;
    assign cx_fix   = {3'b0, cfg.centre_x, {FRAC_W{1'b0}}};
    assign cy_fix   = {3'b0, cfg.centre_y, {FRAC_W{1'b0}}};
    assign pair     = edge_ends(edge_reg);

    // pair being turned: z axis (x,y), x axis (y,z), y axis (z,x)
    always_comb begin
        case (axis_reg)
            2'd0: begin
                op_a  = work_reg.x;
                op_b  = work_reg.y;
                ctr_a = $signed(cx_fix);
                ctr_b = $signed(cy_fix);
            end
            2'd1: begin
                op_a  = work_reg.y;
                op_b  = work_reg.z;
                ctr_a = $signed(cy_fix);
                ctr_b = '0;
            end
            default: begin
                op_a  = work_reg.z;
                op_b  = work_reg.x;
                ctr_a = '0;
                ctr_b = $signed(cx_fix);
            end
        endcase
        sin_sel = $signed(sin_reg[axis_reg]);
        cos_sel = $signed(cos_reg[axis_reg]);
        diff_a  = {op_a[VERT_W-1], op_a} - ctr_a;
        diff_b  = {op_b[VERT_W-1], op_b} - ctr_b;
        sum_a   = (acc_a_reg >>> FRAC_W) + ACC_W'(ctr_a);
        sum_b   = (acc_b_reg >>> FRAC_W) + ACC_W'(ctr_b);
        new_a   = sum_a[VERT_W-1:0];
        new_b   = sum_b[VERT_W-1:0];
    end

    always_comb begin
        case (step_reg[1:0])
            2'd0:    speed_sel = cfg.speed_z_axis;
            2'd1:    speed_sel = cfg.speed_x_axis;
            default: speed_sel = cfg.speed_y_axis;
        endcase
        ph_slot    = 2'(step_reg - 3'd1);
        trig_slot  = step_reg - 3'd1;
        trig_phase = phase_reg[step_reg[2:1]];
        cos_phase  = trig_phase + QUARTER_TURN;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        vtx_next   = vtx_reg;
        axis_next  = axis_reg;
        edge_next  = edge_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    vtx_next   = '0;
                    step_next  = '0;
                    state_next = item.restart ? ST_BUILD : ST_PHASE;
                end
            end
            ST_BUILD: begin
                vtx_next = vtx_reg + 1'b1;
                if (vtx_reg == VTX_W'(VERTEX_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_PHASE: begin
                step_next = step_reg + 3'd1;
                if (step_reg == PHASE_LAST) begin
                    step_next  = '0;
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: begin
                step_next = step_reg + 3'd1;
                if (step_reg == TRIG_LAST) begin
                    step_next  = '0;
                    vtx_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: begin
                step_next  = '0;
                axis_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                step_next = step_reg + 3'd1;
                if (step_reg == ROT_LAST) begin
                    step_next = '0;
                    if (axis_reg == AXIS_LAST)
                        state_next = ST_WRITE;
                    else
                        axis_next = axis_reg + 2'd1;
                end
            end
            ST_WRITE: begin
                if (vtx_reg == VTX_W'(VERTEX_COUNT - 1)) begin
                    edge_next  = '0;
                    state_next = ST_EDGE_RD;
                end
                else begin
                    vtx_next   = vtx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EDGE_RD: state_next = ST_EDGE_OUT;
            ST_EDGE_OUT: begin
                if (emit_ready) begin
                    if (edge_reg == EDGE_W'(EDGE_COUNT - 1))
                        state_next = ST_IDLE;
                    else begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = ST_EDGE_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs towards memory, rom, multiplier and result channel
    always_comb begin
        busy            = (state_reg != ST_IDLE);
        emit_valid      = (state_reg == ST_EDGE_OUT);
        mem_req         = '0;
        mem_req.wr_addr = vtx_reg;
        mem_req.wr_data = work_reg;
        rom_rd_en       = 1'b0;
        rom_index       = trig_phase[PHASE_W-1 -: IDX_W];
        mul_a           = diff_a;
        mul_b           = MULB_W'(cos_sel);
        unique case (state_reg)
            ST_BUILD: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = cube_corner(cfg.centre_x, cfg.centre_y, cfg.half_size,
                                              vtx_reg);
            end
            ST_PHASE: begin
                mul_a = $signed({3'b0, delta_reg});
                mul_b = $signed({1'b0, speed_sel});
            end
            ST_TRIG: begin
                rom_rd_en = (step_reg != TRIG_LAST);
                rom_index = step_reg[0] ? cos_phase[PHASE_W-1 -: IDX_W]
                                        : trig_phase[PHASE_W-1 -: IDX_W];
            end
            ST_READ: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = vtx_reg;
            end
            ST_ROT: begin
                case (step_reg)
                    3'd0: begin mul_a = diff_a; mul_b = MULB_W'(cos_sel); end
                    3'd1: begin mul_a = diff_b; mul_b = MULB_W'(sin_sel); end
                    3'd2: begin mul_a = diff_a; mul_b = MULB_W'(sin_sel); end
                    default: begin mul_a = diff_b; mul_b = MULB_W'(cos_sel); end
                endcase
            end
            ST_WRITE: mem_req.wr_en = 1'b1;
            ST_EDGE_RD: begin
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = pair.a;
                mem_req.rd_addr_b = pair.b;
            end
            default: ;
        endcase
        emit_item.x_start     = screen_coord(rd_data_a.x);
        emit_item.y_start     = screen_coord(rd_data_a.y);
        emit_item.x_end       = screen_coord(rd_data_b.x);
        emit_item.y_end       = screen_coord(rd_data_b.y);
        emit_item.line_colour = colour_reg;
        emit_item.last_edge   = (edge_reg == EDGE_W'(EDGE_COUNT - 1));
    end

    // datapath registers
    always_comb begin
        time_last_next = time_last_reg;
        colour_next    = colour_reg;
        delta_next     = delta_reg;
        phase_next     = phase_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        mul_next       = mul_prod;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        work_next      = work_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (item.restart) begin
                        time_last_next = '0;
                        colour_next    = cfg.start_colour;
                    end
                    else begin
                        delta_next     = item.time_now - time_last_reg;
                        time_last_next = item.time_now;
                    end
                end
            end
            ST_PHASE: begin
                if (step_reg != 3'd0)
                    phase_next[ph_slot] = mul_reg[31:16];
            end
            ST_TRIG: begin
                if (step_reg != 3'd0) begin
                    if (trig_slot[0])
                        cos_next[trig_slot[2:1]] = rom_data;
                    else
                        sin_next[trig_slot[2:1]] = rom_data;
                end
            end
            ST_LOAD: work_next = rd_data_a;
            ST_ROT: begin
                case (step_reg)
                    3'd1: acc_a_next = ACC_W'(mul_reg);
                    3'd2: acc_a_next = acc_a_reg - ACC_W'(mul_reg);
                    3'd3: acc_b_next = ACC_W'(mul_reg);
                    3'd4: acc_b_next = acc_b_reg + ACC_W'(mul_reg);
                    3'd5: begin
                        case (axis_reg)
                            2'd0: begin work_next.x = new_a; work_next.y = new_b; end
                            2'd1: begin work_next.y = new_a; work_next.z = new_b; end
                            default: begin work_next.z = new_a; work_next.x = new_b; end
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_EDGE_OUT: begin
                if (emit_ready && emit_item.last_edge && cfg.colour_cycle)
                    colour_next = colour_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            vtx_reg       <= '0;
            axis_reg      <= '0;
            edge_reg      <= '0;
            time_last_reg <= '0;
            colour_reg    <= CFG_RESET.start_colour;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            vtx_reg       <= vtx_next;
            axis_reg      <= axis_next;
            edge_reg      <= edge_next;
            time_last_reg <= time_last_next;
            colour_reg    <= colour_next;
        end
    end

    always_ff @(posedge clk) begin
        delta_reg <= delta_next;
        phase_reg <= phase_next;
        sin_reg   <= sin_next;
        cos_reg   <= cos_next;
        mul_reg   <= mul_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        work_reg  <= work_next;
    end

endmodule

// ===== rtl/core/wireframe_cube_rotator_unit.sv =====
// top level of the wireframe cube rotator: config registers, result register
// depends on crot_pkg, crot_vertex_mem, crot_sine_rom and crot_engine
//
//   port group   direction  handshake          payload
//   in_*         request    in_valid/in_stall  in_item_t (restart, time_now)
//   out_*        request    out_valid/out_stall out_item_t (one edge line)
//   cfg_*        write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a frame does 3 phase products and 6 rom reads, then per vertex a read, 12
// products on the one multiplier and a write, then per edge a read and an
// output that waits out result stalls; a restart does 8 writes
// reset leaves the reset cube readable at once, no clearing pass
// one item is worked at a time; in_stall is high until the frame is out
module wireframe_cube_rotator_unit #(
    parameter int SINE_ENTRIES = crot_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  crot_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output crot_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crot_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crot_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import crot_pkg::*;

    cfg_t       cfg_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic       busy;
    logic       start;
    logic       emit_valid;
    logic       emit_ready;
    out_item_t  emit_item;
    mem_req_t   mem_req;
    vertex_t    rd_data_a;
    vertex_t    rd_data_b;
    logic       rom_rd_en;
    logic [$clog2(SINE_ENTRIES)-1:0] rom_index;
    logic signed [SINE_W-1:0]        rom_data;

    assign cfg_ready  = 1'b1;
    assign in_stall   = busy;
    assign start      = in_valid && !busy;
    assign emit_ready = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTRE_X:     cfg_reg.centre_x     <= cfg_data[COORD_W-1:0];
                CFG_CENTRE_Y:     cfg_reg.centre_y     <= cfg_data[COORD_W-1:0];
                CFG_HALF_SIZE:    cfg_reg.half_size    <= cfg_data[HALF_W-1:0];
                CFG_SPEED_X:      cfg_reg.speed_x_axis <= cfg_data[SPEED_W-1:0];
                CFG_SPEED_Y:      cfg_reg.speed_y_axis <= cfg_data[SPEED_W-1:0];
                CFG_SPEED_Z:      cfg_reg.speed_z_axis <= cfg_data[SPEED_W-1:0];
                CFG_COLOUR_CYCLE: cfg_reg.colour_cycle <= cfg_data[0];
                CFG_START_COLOUR: cfg_reg.start_colour <= cfg_data[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid && emit_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (emit_valid && emit_ready)
            out_data_reg <= emit_item;
    end

    crot_engine #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (start),
        .item       (in_data),
        .busy       (busy),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_item  (emit_item),
        .mem_req    (mem_req),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .rom_rd_en  (rom_rd_en),
        .rom_index  (rom_index),
        .rom_data   (rom_data)
    );

    crot_vertex_mem u_vertex_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    crot_sine_rom #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_sine_rom (
        .clk      (clk),
        .rd_en    (rom_rd_en),
        .rd_index (rom_index),
        .rd_data  (rom_data)
    );

endmodule

// ===== rtl/core/crot_checker.sv =====
// port-level checks for the cube rotator, bound to the top level
// depends on crot_pkg and wireframe_cube_rotator_unit
module crot_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input crot_pkg::out_item_t out_data
);
    import crot_pkg::*;

    // a held request keeps its line
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every accepted request occupies the block
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block free right after accepting a request");

    // a frame in flight keeps the input closed
    a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_edge |-> in_stall)
        else $error("input open during a frame");

    // the line after a last edge opens a new frame
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last_edge |=> !(out_valid && out_data.last_edge))
        else $error("last edge followed by another last edge");

endmodule

bind wireframe_cube_rotator_unit crot_checker u_crot_checker (.*);

// ===== bench/testbench.sv =====
// self-checking bench for wireframe_cube_rotator_unit: directed and random frames
// predicts every edge line from its own copy of cube state; depends on crot_pkg
`timescale 1ns / 1ps
module testbench;
    import crot_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    wireframe_cube_rotator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model of the cube state and registers
    cfg_t        regs;
    longint      vx [VERTEX_COUNT];
    longint      vy [VERTEX_COUNT];
    longint      vz [VERTEX_COUNT];
    logic [23:0] last_time;
    logic [7:0]  colour;
    int          sine_lut [1024];
    out_item_t   lines_due [$];
    int          errors = 0;
    bit          idle_on = 1'b1;
    int          hold_left = 0;

    localparam int EDGE_A [EDGE_COUNT] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
    localparam int EDGE_B [EDGE_COUNT] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

    function automatic longint wrap26(longint v);
        logic [25:0] u;
        u = v[25:0];
        return longint'(signed'(u));
    endfunction

    function automatic logic [9:0] to_screen(longint v);
        longint p;
        p = v >>> 14;
        if (p < 0)
            return 10'd0;
        if (p > 1023)
            return 10'd1023;
        return p[9:0];
    endfunction

    function automatic logic [15:0] axis_phase(logic [23:0] d, logic [23:0] spd);
        logic [47:0] prod;
        prod = d * spd;
        return prod[31:16];
    endfunction

    task automatic rebuild_cube();
        longint h;
        longint sx;
        longint sy;
        longint sz;
        h = regs.half_size;
        for (int i = 0; i < VERTEX_COUNT; i++)
        begin
            sx = (i % 4 == 1 || i % 4 == 2) ? h : -h;
            sy = (i % 4 >= 2) ? h : -h;
            sz = (i >= 4) ? h : -h;
            vx[i] = wrap26((longint'(regs.centre_x) + sx) * 16384);
            vy[i] = wrap26((longint'(regs.centre_y) + sy) * 16384);
            vz[i] = wrap26(sz * 16384);
        end
    endtask

    // rotates (a, b) about (ca, cb) by the given phase
    task automatic turn(inout longint a, inout longint b, input longint ca,
                        input longint cb, input logic [15:0] ph);
        longint s;
        longint c;
        longint da;
        longint db;
        logic [15:0] cph;
        cph = ph + 16'd16384;
        s = sine_lut[ph[15:6]];
        c = sine_lut[cph[15:6]];
        da = a - ca;
        db = b - cb;
        a = wrap26(((da * c - db * s) >>> 14) + ca);
        b = wrap26(((da * s + db * c) >>> 14) + cb);
    endtask

    task automatic predict_request(in_item_t it);
        logic [23:0] delta;
        longint      cx;
        longint      cy;
        logic [15:0] ph;
        out_item_t   ln;
        if (it.restart)
        begin
            rebuild_cube();
            last_time = '0;
            colour = regs.start_colour;
            return;
        end
        delta = it.time_now - last_time;
        last_time = it.time_now;
        cx = longint'(regs.centre_x) * 16384;
        cy = longint'(regs.centre_y) * 16384;
        ph = axis_phase(delta, regs.speed_z_axis);
        for (int i = 0; i < VERTEX_COUNT; i++)
            turn(vx[i], vy[i], cx, cy, ph);
        ph = axis_phase(delta, regs.speed_x_axis);
        for (int i = 0; i < VERTEX_COUNT; i++)
            turn(vy[i], vz[i], cy, 0, ph);
        ph = axis_phase(delta, regs.speed_y_axis);
        for (int i = 0; i < VERTEX_COUNT; i++)
            turn(vz[i], vx[i], 0, cx, ph);
        for (int e = 0; e < EDGE_COUNT; e++)
        begin
            ln.x_start     = to_screen(vx[EDGE_A[e]]);
            ln.y_start     = to_screen(vy[EDGE_A[e]]);
            ln.x_end       = to_screen(vx[EDGE_B[e]]);
            ln.y_end       = to_screen(vy[EDGE_B[e]]);
            ln.line_colour = colour;
            ln.last_edge   = (e == EDGE_COUNT - 1);
            lines_due.push_back(ln);
        end
        if (regs.colour_cycle)
            colour = colour + 8'd1;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver: random stalls, long hold-offs on request, field checks
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lines_due.size() == 0)
                report("unexpected line", 1, 0);
            else
            begin
                want = lines_due.pop_front();
                if (out_data.x_start != want.x_start)
                    report("x_start", out_data.x_start, want.x_start);
                if (out_data.y_start != want.y_start)
                    report("y_start", out_data.y_start, want.y_start);
                if (out_data.x_end != want.x_end)
                    report("x_end", out_data.x_end, want.x_end);
                if (out_data.y_end != want.y_end)
                    report("y_end", out_data.y_end, want.y_end);
                if (out_data.line_colour != want.line_colour)
                    report("line_colour", out_data.line_colour, want.line_colour);
                if (out_data.last_edge != want.last_edge)
                    report("last_edge", out_data.last_edge, want.last_edge);
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 31);
    end

    // in_valid stays high from one request to the next unless a gap is drawn
    task automatic send_request(logic rs, logic [23:0] t);
        in_item_t it;
        while (idle_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            in_data  <= '{restart: 1'($urandom_range(1)), time_now: 24'($urandom)};
            @(posedge clk);
        end
        it.restart  = rs;
        it.time_now = t;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lines_due.size() != 0)
            @(posedge clk);
        // a trailing restart yields no lines but may still be rebuilding
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CENTRE_X:     regs.centre_x     = val[9:0];
            CFG_CENTRE_Y:     regs.centre_y     = val[9:0];
            CFG_HALF_SIZE:    regs.half_size    = val[8:0];
            CFG_SPEED_X:      regs.speed_x_axis = val;
            CFG_SPEED_Y:      regs.speed_y_axis = val;
            CFG_SPEED_Z:      regs.speed_z_axis = val;
            CFG_COLOUR_CYCLE: regs.colour_cycle = val[0];
            CFG_START_COLOUR: regs.start_colour = val[7:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_regs();
        write_reg(CFG_CENTRE_X, 24'($urandom));
        write_reg(CFG_CENTRE_Y, 24'($urandom));
        write_reg(CFG_HALF_SIZE, 24'($urandom));
        write_reg(CFG_SPEED_X, 24'($urandom));
        write_reg(CFG_SPEED_Y, 24'($urandom));
        write_reg(CFG_SPEED_Z, 24'($urandom));
        write_reg(CFG_COLOUR_CYCLE, 24'($urandom));
        write_reg(CFG_START_COLOUR, 24'($urandom));
        end_writes();
    endtask

    task automatic test_reset_cube();
        send_request(1'b0, 24'd0);
        send_request(1'b0, 24'd1);
        send_request(1'b0, 24'hFFFFFF);
        send_request(1'b0, 24'd5);
        send_request(1'b1, 24'hFFFFFF);
        send_request(1'b0, 24'h800000);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_CENTRE_X, 24'd1023);
        write_reg(CFG_CENTRE_Y, 24'd0);
        write_reg(CFG_HALF_SIZE, 24'd511);
        write_reg(CFG_SPEED_X, 24'hFFFFFF);
        write_reg(CFG_SPEED_Y, 24'd0);
        write_reg(CFG_SPEED_Z, 24'hFFFFFF);
        write_reg(CFG_START_COLOUR, 24'd255);
        write_reg(8'd200, 24'h123456);
        end_writes();
        send_request(1'b1, 24'd0);
        send_request(1'b0, 24'h7FFFFF);
        send_request(1'b0, 24'hFFFFFF);
        send_request(1'b0, 24'd3);
        drain();
        write_reg(CFG_CENTRE_X, 24'd0);
        write_reg(CFG_CENTRE_Y, 24'd1023);
        write_reg(CFG_HALF_SIZE, 24'd0);
        write_reg(CFG_SPEED_Y, 24'hFFFFFF);
        write_reg(CFG_COLOUR_CYCLE, 24'd0);
        write_reg(CFG_START_COLOUR, 24'd0);
        end_writes();
        send_request(1'b1, 24'd77);
        send_request(1'b0, 24'd1000);
        send_request(1'b0, 24'd2000);
        drain();
        write_reg(CFG_HALF_SIZE, 24'd511);
        write_reg(CFG_COLOUR_CYCLE, 24'd1);
        write_reg(CFG_START_COLOUR, 24'd254);
        end_writes();
        send_request(1'b1, 24'd0);
        for (int i = 0; i < 4; i++)
            send_request(1'b0, 24'($urandom));
        drain();
    endtask

    task automatic test_random_frames(int count);
        for (int i = 0; i < count; i++)
            send_request($urandom_range(99) < 10, 24'($urandom));
        drain();
    endtask

    task automatic test_backpressure();
        hold_left = 600;
        for (int i = 0; i < 6; i++)
            send_request(1'b0, 24'($urandom));
        drain();
    endtask

    initial
    begin
        real ang;
        int  q;
        int  rem;
        int  r;
        for (int i = 0; i < 1024; i++)
        begin
            q   = (4 * i) / 1024;
            rem = 4 * i - q * 1024;
            if (q % 2 == 1)
                rem = 1024 - rem;
            ang = 3.14159265358979323846 / 2.0 * rem / 1024.0;
            r   = $rtoi(16384.0 * $sin(ang) + 0.5);
            if (r > 16384)
                r = 16384;
            sine_lut[i] = (q >= 2) ? -r : r;
        end
        regs = '{centre_x: 10'd128, centre_y: 10'd96, half_size: 9'd48,
                 speed_x_axis: 24'd214748, speed_y_axis: 24'd644245,
                 speed_z_axis: 24'd429497, colour_cycle: 1'b1, start_colour: 8'd1};
        rebuild_cube();
        last_time = '0;
        colour = 8'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_cube();
        test_register_extremes();
        test_random_frames(110);
        random_regs();
        test_random_frames(100);
        random_regs();
        idle_on = 1'b0;
        test_random_frames(100);
        idle_on = 1'b1;
        random_regs();
        test_backpressure();
        test_random_frames(100);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
